/* src/fht_pkg.sv */
package fht_pkg;

	// stuck-sensor supervision window in milliseconds
	localparam logic [31:0] STUCK_TIME_MS = 32'd1800000;

	// register reset values
	localparam logic signed [11:0] RST_ROOM_SETPOINT    = 12'sd336;
	localparam logic               RST_SUMMER_MODE      = 1'b0;
	localparam logic signed [11:0] RST_SETPOINT_MIN     = 12'sd80;
	localparam logic signed [11:0] RST_SETPOINT_MAX     = 12'sd464;
	localparam logic [7:0]         RST_ROOM_HYSTERESIS  = 8'd8;
	localparam logic [7:0]         RST_NIGHT_REDUCTION  = 8'd32;
	localparam logic [7:0]         RST_FLOOR_HYSTERESIS = 8'd16;
	localparam logic [7:0]         RST_STUCK_DELTA      = 8'd16;

	// configuration port widths
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 12;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROOM_SETPOINT    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SUMMER_MODE      = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_MIN     = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_MAX     = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROOM_HYSTERESIS  = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NIGHT_REDUCTION  = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR_HYSTERESIS = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_STUCK_DELTA      = 4'd7;

	// sticky error codes
	typedef enum logic [1:0] {
		ERR_NONE         = 2'd0,
		ERR_DISCONNECTED = 2'd1,
		ERR_NOT_REACTING = 2'd2
	} err_t;

	// one control tick as captured from the input channel
	typedef struct packed {
		logic [31:0]        now_ms;
		logic signed [11:0] floor_temp;
		logic               floor_valid;
		logic signed [12:0] room_temp;
		logic               frost_protect;
		logic               window_one_open;
		logic               window_two_open;
		logic               night_mode;
	} tick_t;

endpackage

/* src/floor_heating_thermostat.sv */
// Floor heating thermostat, two-point room regulation with hysteresis.
//
// Input channel: one beat per control tick (timestamp, floor and room
// temperatures, sensor-valid flag, frost, window and night flags), taken on a
// rising edge with in_valid high and in_stall low. Output channel: one beat
// per tick (relay command, working setpoint, error code, substituted floor
// value, over-temperature latch), taken with out_valid high and out_stall low.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index selects the
// register, cfg_data carries the value; cfg_ready is always high and writes
// to an unused index are dropped. Write registers only while the block idles.
//
// An input register, then one pass of compare/add logic into the result
// register, where the relay, latch, timer and error state commit. Throughput
// is one tick per cycle while the receiver does not stall. When the receiver
// stalls, the result register holds and the input register holds behind it;
// in_stall rises once both are full.
// Reset clears relay, latch, timer and error state and loads the register
// defaults; both pipeline stages come up empty.
module floor_heating_thermostat
	import fht_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [31:0]           now_ms,
	input  logic signed [11:0]    floor_temp,
	input  logic                  floor_valid,
	input  logic signed [12:0]    room_temp,
	input  logic                  frost_protect,
	input  logic                  window_one_open,
	input  logic                  window_two_open,
	input  logic                  night_mode,
	// output channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  relay_on,
	output logic signed [11:0]    working_setpoint,
	output logic [1:0]            error_code,
	output logic signed [11:0]    floor_used,
	output logic                  floor_over_limit
);

	// configuration registers
	logic signed [11:0] room_setpoint_q;
	logic               summer_mode_q;
	logic signed [11:0] setpoint_min_q;
	logic signed [11:0] setpoint_max_q;
	logic [7:0]         room_hyst_q;
	logic [7:0]         night_red_q;
	logic [7:0]         floor_hyst_q;
	logic [7:0]         stuck_delta_q;

	// control state
	logic               relay_q;
	logic               latch_q;
	logic [31:0]        on_time_q;
	logic signed [11:0] on_floor_q;
	err_t               err_q;

	// pipeline
	tick_t              tick_s1;
	logic               valid_s1;
	logic               valid_s2;
	logic               relay_s2;
	logic signed [11:0] wsp_s2;
	logic [1:0]         err_s2;
	logic signed [11:0] floor_s2;
	logic               latch_s2;

	logic               out_free;
	logic               commit;
	logic               in_take;

	// datapath
	logic signed [11:0] floor_c;
	err_t               err_in_c;
	logic signed [12:0] wsp_raw_c;
	logic signed [12:0] wsp_hi_c;
	logic signed [12:0] wsp_lo_c;
	logic signed [11:0] wsp_c;
	logic signed [13:0] room_ext_c;
	logic signed [13:0] wsp_ext_c;
	logic signed [13:0] band_lo_c;
	logic               relay_reg_c;
	logic signed [12:0] floor_rel_c;
	logic               latch_c;
	logic               relay_c;
	logic               rising_c;
	logic [31:0]        on_time_c;
	logic signed [11:0] on_floor_c;
	logic [31:0]        elapsed_c;
	logic signed [12:0] rise_c;
	logic               stuck_c;
	err_t               err_c;

	// handshake control
	assign out_free  = !valid_s2 || !out_stall;
	assign commit    = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			room_setpoint_q <= RST_ROOM_SETPOINT;
			summer_mode_q   <= RST_SUMMER_MODE;
			setpoint_min_q  <= RST_SETPOINT_MIN;
			setpoint_max_q  <= RST_SETPOINT_MAX;
			room_hyst_q     <= RST_ROOM_HYSTERESIS;
			night_red_q     <= RST_NIGHT_REDUCTION;
			floor_hyst_q    <= RST_FLOOR_HYSTERESIS;
			stuck_delta_q   <= RST_STUCK_DELTA;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ROOM_SETPOINT:    room_setpoint_q <= cfg_data;
				REG_SUMMER_MODE:      summer_mode_q   <= cfg_data[0];
				REG_SETPOINT_MIN:     setpoint_min_q  <= cfg_data;
				REG_SETPOINT_MAX:     setpoint_max_q  <= cfg_data;
				REG_ROOM_HYSTERESIS:  room_hyst_q     <= cfg_data[7:0];
				REG_NIGHT_REDUCTION:  night_red_q     <= cfg_data[7:0];
				REG_FLOOR_HYSTERESIS: floor_hyst_q    <= cfg_data[7:0];
				REG_STUCK_DELTA:      stuck_delta_q   <= cfg_data[7:0];
				default:              ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			tick_s1.now_ms          <= now_ms;
			tick_s1.floor_temp      <= floor_temp;
			tick_s1.floor_valid     <= floor_valid;
			tick_s1.room_temp       <= room_temp;
			tick_s1.frost_protect   <= frost_protect;
			tick_s1.window_one_open <= window_one_open;
			tick_s1.window_two_open <= window_two_open;
			tick_s1.night_mode      <= night_mode;
		end
	end

	// floor fallback and disconnect error
	always_comb begin
		floor_c  = tick_s1.floor_valid ? tick_s1.floor_temp : setpoint_min_q;
		err_in_c = tick_s1.floor_valid ? err_q : ERR_DISCONNECTED;
	end

	// working setpoint, limited to max first and then raised to min
	always_comb begin
		priority if (tick_s1.frost_protect || tick_s1.window_one_open ||
		             tick_s1.window_two_open) begin
			wsp_raw_c = 13'(setpoint_min_q);
		end else if (tick_s1.night_mode) begin
			wsp_raw_c = 13'(room_setpoint_q) - $signed({5'b0, night_red_q});
		end else begin
			wsp_raw_c = 13'(room_setpoint_q);
		end
		wsp_hi_c = (wsp_raw_c > 13'(setpoint_max_q)) ? 13'(setpoint_max_q) : wsp_raw_c;
		wsp_lo_c = (wsp_hi_c < 13'(setpoint_min_q)) ? 13'(setpoint_min_q) : wsp_hi_c;
		wsp_c    = wsp_lo_c[11:0];
	end

	// room regulation with switch-on band
	always_comb begin
		room_ext_c = 14'(tick_s1.room_temp);
		wsp_ext_c  = 14'(wsp_c);
		band_lo_c  = wsp_ext_c - $signed({6'b0, room_hyst_q});
		priority if (room_ext_c > wsp_ext_c) begin
			relay_reg_c = 1'b0;
		end else if (room_ext_c <= band_lo_c) begin
			relay_reg_c = 1'b1;
		end else begin
			relay_reg_c = relay_q;
		end
	end

	// floor over-temperature latch
	always_comb begin
		floor_rel_c = 13'(setpoint_max_q) - $signed({5'b0, floor_hyst_q});
		priority if (floor_c >= setpoint_max_q) begin
			latch_c = 1'b1;
		end else if (13'(floor_c) < floor_rel_c) begin
			latch_c = 1'b0;
		end else begin
			latch_c = latch_q;
		end
	end

	// forced off, switch-on capture and stuck-sensor check
	always_comb begin
		relay_c    = relay_reg_c && !latch_c && !summer_mode_q && (err_in_c == ERR_NONE);
		rising_c   = relay_c && !relay_q;
		on_time_c  = rising_c ? tick_s1.now_ms : on_time_q;
		on_floor_c = rising_c ? floor_c : on_floor_q;
		elapsed_c  = tick_s1.now_ms - on_time_c;
		rise_c     = 13'(floor_c) - 13'(on_floor_c);
		stuck_c    = relay_c && (elapsed_c > STUCK_TIME_MS) &&
		             (rise_c < $signed({5'b0, stuck_delta_q}));
		err_c      = stuck_c ? ERR_NOT_REACTING : err_in_c;
	end

	// state commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_q    <= 1'b0;
			latch_q    <= 1'b0;
			on_time_q  <= '0;
			on_floor_q <= '0;
			err_q      <= ERR_NONE;
		end else if (commit) begin
			relay_q    <= relay_c;
			latch_q    <= latch_c;
			on_time_q  <= on_time_c;
			on_floor_q <= on_floor_c;
			err_q      <= err_c;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			relay_s2 <= relay_c;
			wsp_s2   <= wsp_c;
			err_s2   <= err_c;
			floor_s2 <= floor_c;
			latch_s2 <= latch_c;
		end
	end

	assign out_valid        = valid_s2;
	assign relay_on         = relay_s2;
	assign working_setpoint = wsp_s2;
	assign error_code       = err_s2;
	assign floor_used       = floor_s2;
	assign floor_over_limit = latch_s2;

	// errors stay set until reset
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q != ERR_NONE |=> err_q != ERR_NONE)
		else $error("error state cleared without reset");

	// a reported relay-on beat never coexists with the latch or a disconnect
	a_relay_forced: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && relay_on |-> !floor_over_limit && error_code != ERR_DISCONNECTED)
		else $error("relay reported on while forced off");

	// the result register tracks the committed state
	a_state_match: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> relay_s2 == relay_q && latch_s2 == latch_q && err_s2 == err_q)
		else $error("result beat differs from committed state");

	// no undefined error code leaves the block
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> error_code != 2'd3)
		else $error("undefined error code");

endmodule

/* dv/thermostat_check_pkg.sv */
`timescale 1ns / 1ps

package thermostat_check_pkg;

	import fht_pkg::*;

	// one relay command beat as seen on the output channel
	typedef struct packed {
		logic               relay_on;
		logic signed [11:0] working_setpoint;
		err_t               error_code;
		logic signed [11:0] floor_used;
		logic               floor_over_limit;
	} command_t;

	// shadow copy of the thermostat: registers, regulation state, pending commands
	class thermostat_shadow;
		logic signed [11:0] room_sp;
		logic signed [11:0] sp_min;
		logic signed [11:0] sp_max;
		logic               summer;
		logic [7:0]         room_hyst;
		logic [7:0]         night_red;
		logic [7:0]         floor_hyst;
		logic [7:0]         stuck_delta;

		logic               relay;
		logic               latch;
		logic               prev_relay;
		logic [31:0]        on_since;
		logic signed [12:0] on_floor;
		err_t               err;

		command_t pending_commands[$];
		int ticks;
		int checked;
		int writes;
		int mismatches;
		int relay_on_seen;
		int latch_seen;
		int err_seen[3];

		function new();
			room_sp = RST_ROOM_SETPOINT;
			summer = RST_SUMMER_MODE;
			sp_min = RST_SETPOINT_MIN;
			sp_max = RST_SETPOINT_MAX;
			room_hyst = RST_ROOM_HYSTERESIS;
			night_red = RST_NIGHT_REDUCTION;
			floor_hyst = RST_FLOOR_HYSTERESIS;
			stuck_delta = RST_STUCK_DELTA;
			relay = 1'b0;
			latch = 1'b0;
			prev_relay = 1'b0;
			on_since = '0;
			on_floor = '0;
			err = ERR_NONE;
		endfunction

		// register write beat, unused indexes fall through
		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			writes++;
			case (idx)
				REG_ROOM_SETPOINT:    room_sp = data;
				REG_SUMMER_MODE:      summer = data[0];
				REG_SETPOINT_MIN:     sp_min = data;
				REG_SETPOINT_MAX:     sp_max = data;
				REG_ROOM_HYSTERESIS:  room_hyst = data[7:0];
				REG_NIGHT_REDUCTION:  night_red = data[7:0];
				REG_FLOOR_HYSTERESIS: floor_hyst = data[7:0];
				REG_STUCK_DELTA:      stuck_delta = data[7:0];
				default: ;
			endcase
		endfunction

		// working setpoint: frost/window pick the minimum, max clamp first so min wins
		function int setpoint_for(tick_t t);
			int w;
			if (t.frost_protect || t.window_one_open || t.window_two_open)
				w = int'(sp_min);
			else if (t.night_mode)
				w = int'(room_sp) - int'(night_red);
			else
				w = int'(room_sp);
			if (w > int'(sp_max))
				w = int'(sp_max);
			if (w < int'(sp_min))
				w = int'(sp_min);
			return w;
		endfunction

		// accepted tick: advance the shadow state and queue the command it yields
		function void take_tick(tick_t t);
			int fu;
			int wsp;
			int room;
			int limit;
			logic [31:0] elapsed;
			command_t c;
			ticks++;
			room = int'(t.room_temp);
			limit = int'(sp_max);

			// sensor fallback, error is sticky
			if (t.floor_valid) begin
				fu = int'(t.floor_temp);
			end else begin
				fu = int'(sp_min);
				err = ERR_DISCONNECTED;
			end

			// two-point room regulation
			wsp = setpoint_for(t);
			if (room > wsp)
				relay = 1'b0;
			else if (room <= wsp - int'(room_hyst))
				relay = 1'b1;

			// floor over-temperature latch
			if (fu >= limit)
				latch = 1'b1;
			else if (fu < limit - int'(floor_hyst))
				latch = 1'b0;

			if (latch || summer || err != ERR_NONE)
				relay = 1'b0;

			// stuck sensor supervision, elapsed time wraps mod 2^32
			if (relay && !prev_relay) begin
				on_since = t.now_ms;
				on_floor = 13'(fu);
			end
			elapsed = t.now_ms - on_since;
			if (relay && elapsed > STUCK_TIME_MS && fu - int'(on_floor) < int'(stuck_delta))
				err = ERR_NOT_REACTING;
			prev_relay = relay;

			c.relay_on = relay;
			c.working_setpoint = wsp[11:0];
			c.error_code = err;
			c.floor_used = fu[11:0];
			c.floor_over_limit = latch;
			pending_commands.push_back(c);
			relay_on_seen += int'(relay);
			latch_seen += int'(latch);
			err_seen[err]++;
		endfunction

		// compare one output beat against the oldest pending command
		function void check_command(command_t got);
			command_t want;
			if (pending_commands.size() == 0) begin
				$error("output beat with no command pending");
				mismatches++;
				return;
			end
			want = pending_commands.pop_front();
			checked++;
			if (got.relay_on !== want.relay_on) begin
				$error("relay_on: expected %0d, got %0d", want.relay_on, got.relay_on);
				mismatches++;
			end
			if (got.working_setpoint !== want.working_setpoint) begin
				$error("working_setpoint: expected %0d, got %0d",
					want.working_setpoint, got.working_setpoint);
				mismatches++;
			end
			if (got.error_code !== want.error_code) begin
				$error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
				mismatches++;
			end
			if (got.floor_used !== want.floor_used) begin
				$error("floor_used: expected %0d, got %0d", want.floor_used, got.floor_used);
				mismatches++;
			end
			if (got.floor_over_limit !== want.floor_over_limit) begin
				$error("floor_over_limit: expected %0d, got %0d",
					want.floor_over_limit, got.floor_over_limit);
				mismatches++;
			end
		endfunction
	endclass

endpackage

/* dv/tb_floor_heating_thermostat.sv */
`timescale 1ns / 1ps

module tb_floor_heating_thermostat;

	import fht_pkg::*;
	import thermostat_check_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd15;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [31:0]           now_ms = '0;
	logic signed [11:0]    floor_temp = '0;
	logic                  floor_valid = 1'b1;
	logic signed [12:0]    room_temp = '0;
	logic                  frost_protect = 1'b0;
	logic                  window_one_open = 1'b0;
	logic                  window_two_open = 1'b0;
	logic                  night_mode = 1'b0;

	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  relay_on;
	logic signed [11:0]    working_setpoint;
	logic [1:0]            error_code;
	logic signed [11:0]    floor_used;
	logic                  floor_over_limit;

	thermostat_shadow sb = new();

	int idle_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;
	int quiet_cycles = 0;
	logic [31:0] clock_ms = '0;

	floor_heating_thermostat DUT (.*);

	always #5 clk = ~clk;

	// receiver: random stall, or a long counted hold-off when asked
	initial begin : receiver
		forever begin
			@(posedge clk);
			if (hold_cycles != 0) begin
				out_stall <= 1'b1;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// check every output beat
	always @(posedge clk) begin : result_monitor
		command_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.relay_on = relay_on;
			got.working_setpoint = working_setpoint;
			got.error_code = err_t'(error_code);
			got.floor_used = floor_used;
			got.floor_over_limit = floor_over_limit;
			sb.check_command(got);
		end
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic tick_t tick_of(input logic [31:0] stamp, input int fl, input bit ok,
			input int rm, input bit fr, input bit w1, input bit w2, input bit nt);
		tick_t t;
		t.now_ms = stamp;
		t.floor_temp = 12'(fl);
		t.floor_valid = ok;
		t.room_temp = 13'(rm);
		t.frost_protect = fr;
		t.window_one_open = w1;
		t.window_two_open = w2;
		t.night_mode = nt;
		return t;
	endfunction

	// random tick, mostly near the switching thresholds; without faults the
	// sensor stays valid and a long heating stretch gets a floor rise or a warm room
	function automatic tick_t make_tick(input bit faults);
		tick_t t;
		int wsp;
		int rm;
		int fl;
		logic [31:0] elapsed;
		case ($urandom_range(9))
			0:       clock_ms = $urandom();
			1:       clock_ms = clock_ms + $urandom_range(1700000, 2500000);
			default: clock_ms = clock_ms + $urandom_range(20000);
		endcase
		t.now_ms = clock_ms;
		t.frost_protect = ($urandom_range(7) == 0);
		t.window_one_open = ($urandom_range(7) == 0);
		t.window_two_open = ($urandom_range(7) == 0);
		t.night_mode = 1'($urandom_range(1));
		wsp = sb.setpoint_for(t);
		if ($urandom_range(3) != 0)
			rm = wsp + int'($urandom_range(600)) - 300;
		else
			rm = int'($urandom_range(8191)) - 4096;
		if ($urandom_range(2) != 0)
			fl = int'(sb.sp_max) + int'($urandom_range(400)) - 300;
		else
			fl = int'($urandom_range(2927)) - 880;
		if (fl < -880)
			fl = -880;
		if (fl > 2047)
			fl = 2047;
		elapsed = clock_ms - sb.on_since;
		if (!faults && sb.relay && elapsed > STUCK_TIME_MS
				&& fl - int'(sb.on_floor) < int'(sb.stuck_delta)) begin
			if (int'(sb.on_floor) + int'(sb.stuck_delta) <= 2047 && $urandom_range(1) == 1)
				fl = int'(sb.on_floor) + int'(sb.stuck_delta);
			else
				rm = 4095;
		end
		t.floor_temp = 12'(fl);
		t.room_temp = 13'(rm);
		t.floor_valid = faults ? ($urandom_range(3) != 0) : 1'b1;
		return t;
	endfunction

	// one input beat with random idle cycles ahead of it
	task automatic send_tick(input tick_t t);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		now_ms <= t.now_ms;
		floor_temp <= t.floor_temp;
		floor_valid <= t.floor_valid;
		room_temp <= t.room_temp;
		frost_protect <= t.frost_protect;
		window_one_open <= t.window_one_open;
		window_two_open <= t.window_two_open;
		night_mode <= t.night_mode;
		do @(posedge clk); while (in_stall);
		sb.take_tick(t);
	endtask

	// leaves cfg_valid high so back-to-back writes need no extra cycle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_register(idx, data);
	endtask

	// all registers plus a write to an unused index; upper data bits of the narrow registers are junk
	task automatic load_settings(input int sp, su, mn, mx, rh, nr, fh, dl);
		write_reg(REG_ROOM_SETPOINT, 12'(sp));
		write_reg(REG_SUMMER_MODE, {11'($urandom()), 1'(su)});
		write_reg(REG_SETPOINT_MIN, 12'(mn));
		write_reg(REG_SETPOINT_MAX, 12'(mx));
		write_reg(REG_ROOM_HYSTERESIS, {4'($urandom()), 8'(rh)});
		write_reg(REG_NIGHT_REDUCTION, {4'($urandom()), 8'(nr)});
		write_reg(REG_FLOOR_HYSTERESIS, {4'($urandom()), 8'(fh)});
		write_reg(REG_STUCK_DELTA, {4'($urandom()), 8'(dl)});
		write_reg(REG_SPARE, 12'($urandom()));
		cfg_valid <= 1'b0;
	endtask

	task automatic load_random_settings();
		int mn;
		int mx;
		int sw;
		mn = int'($urandom_range(2927)) - 880;
		mx = int'($urandom_range(2927)) - 880;
		if (mn > mx && $urandom_range(3) != 0) begin
			sw = mn;
			mn = mx;
			mx = sw;
		end
		load_settings(int'($urandom_range(2927)) - 880, ($urandom_range(3) == 0), mn, mx,
			$urandom_range(255), $urandom_range(255), $urandom_range(255), $urandom_range(255));
	endtask

	task automatic wait_drained();
		while (sb.pending_commands.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input int count, idle, stall, hold, input bit faults);
		idle_pct = idle;
		stall_pct = stall;
		hold_cycles = hold;
		repeat (count) send_tick(make_tick(faults));
		in_valid <= 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		wait_drained();
	endtask

	initial begin : stimulus
		int idle_mode[5] = '{0, 81, 0, 15, 0};
		int stall_mode[5] = '{0, 0, 81, 15, 0};
		logic [31:0] t0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: room band edges, frost/window/night, floor latch band
		send_tick(tick_of(0, -880, 1, -4096, 0, 0, 0, 0));
		send_tick(tick_of(1000, 100, 1, 336, 0, 0, 0, 0));
		send_tick(tick_of(2000, 100, 1, 337, 0, 0, 0, 0));
		send_tick(tick_of(3000, 100, 1, 329, 0, 0, 0, 0));
		send_tick(tick_of(4000, 100, 1, 328, 0, 0, 0, 0));
		send_tick(tick_of(5000, 100, 1, 80, 1, 0, 0, 0));
		send_tick(tick_of(6000, 100, 1, 81, 0, 1, 0, 0));
		send_tick(tick_of(7000, 100, 1, 72, 0, 0, 1, 0));
		send_tick(tick_of(8000, 100, 1, 296, 0, 0, 0, 1));
		send_tick(tick_of(9000, 464, 1, 296, 0, 0, 0, 0));
		send_tick(tick_of(10000, 448, 1, 296, 0, 0, 0, 0));
		send_tick(tick_of(11000, 447, 1, -100, 0, 0, 0, 0));
		// timer past the window, floor rose exactly by the delta
		send_tick(tick_of(11000 + 1800001, 463, 1, -100, 0, 0, 0, 0));
		send_tick(tick_of(32'hFFFF_FFFF, 2047, 1, 4095, 1, 1, 1, 1));
		in_valid <= 1'b0;
		wait_drained();

		run_phase(150, 0, 0, 0, 0);
		load_settings(2047, 0, -880, 2047, 255, 255, 0, 0);
		run_phase(150, 81, 0, 0, 0);
		// minimum above maximum
		load_settings(-880, 0, 2047, -880, 0, 0, 255, 255);
		run_phase(80, 0, 81, 0, 0);
		load_settings(336, 1, 80, 464, 8, 32, 16, 16);
		run_phase(80, 15, 15, 0, 0);
		// random settings; first phase holds the receiver off to back up the pipe
		for (int k = 0; k < 5; k++) begin
			load_random_settings();
			run_phase(110, idle_mode[k], stall_mode[k], (k == 0) ? 60 : 0, 0);
		end

		// sticky errors: stuck sensor across the timer wrap, then a disconnect over it
		load_settings(336, 0, 80, 464, 8, 32, 16, 16);
		t0 = 32'hFFF0_0000;
		send_tick(tick_of(t0 - 10, 200, 1, 4095, 0, 0, 0, 0));
		send_tick(tick_of(t0, 200, 1, 0, 0, 0, 0, 0));
		send_tick(tick_of(t0 + STUCK_TIME_MS, 200, 1, 0, 0, 0, 0, 0));
		send_tick(tick_of(t0 + STUCK_TIME_MS + 1, 215, 1, 0, 0, 0, 0, 0));
		send_tick(tick_of(t0 + STUCK_TIME_MS + 2, 215, 1, 0, 0, 0, 0, 0));
		send_tick(tick_of(t0 + STUCK_TIME_MS + 3, 2047, 0, 0, 0, 0, 0, 0));
		send_tick(tick_of(t0 + STUCK_TIME_MS + 4, -880, 1, 0, 0, 0, 0, 0));
		in_valid <= 1'b0;
		wait_drained();
		load_random_settings();
		run_phase(120, 15, 15, 0, 1);

		repeat (10) @(posedge clk);
		$display("summary: %0d ticks, %0d relay commands checked, %0d register writes",
			sb.ticks, sb.checked, sb.writes);
		$display("summary: relay on %0d, floor latch %0d, disconnected %0d, not reacting %0d",
			sb.relay_on_seen, sb.latch_seen, sb.err_seen[ERR_DISCONNECTED],
			sb.err_seen[ERR_NOT_REACTING]);
		if (sb.mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
